// ===== rtl/core/mtg_pkg.sv =====
// Package for the MT19937 word generator: sizes, constants, controller
// state and command/status types, and the tempering function.
// No dependencies.
`default_nettype none
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int ADDR_W       = $clog2(STATE_WORDS);
	localparam int IDX_W        = $clog2(STATE_WORDS + 1);
	localparam int WORD_W       = 32;

	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] OFFS_ADDR  = ADDR_W'(TWIST_OFFSET);
	localparam logic [IDX_W-1:0]  FULL_INDEX = IDX_W'(STATE_WORDS);

	localparam logic [WORD_W-1:0] RESET_SEED   = 32'd19650218;
	localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h80000000;
	localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fffffff;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

	// Request codes on req_type.
	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_SEED = 1'b1;

	// Controller states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_SEED    = 7'b0000010,
		S_TW_PRE  = 7'b0000100,
		S_TW_RUN  = 7'b0001000,
		S_TW_LAST = 7'b0010000,
		S_READ    = 7'b0100000,
		S_TEMPER  = 7'b1000000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic seed_load;  // capture seed, clear counter, mark index full
		logic seed_step;  // write one expanded word
		logic tw_pre;     // fetch word 0 ahead of the twist
		logic tw_issue;   // fetch the neighbors of one twisted word
		logic idx_clear;  // twist finished, index back to zero
		logic rd_draw;    // fetch the indexed word
		logic out_load;   // temper the fetched word and present it
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seed_last;
		logic tw_last;
		logic idx_full;
	} status_t;

	// Standard MT19937 output tempering.
	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
		logic [WORD_W-1:0] t;
		t = y_in;
		t = t ^ (t >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mtg_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule
`default_nettype wire

// ===== rtl/core/mtg_ctrl.sv =====
// Controller for the MT19937 word generator: sequences seeding, twisting
// and draws. Depends on mtg_pkg.
`default_nettype none
module mtg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            req_type,
	input  wire mtg_pkg::status_t status,
	output logic                 busy,
	output mtg_pkg::cmd_t        cmd
);
	import mtg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_SEED) begin
						cmd.seed_load = 1'b1;
						state_d       = S_SEED;
					end else if (status.idx_full) begin
						state_d = S_TW_PRE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_SEED: begin
				cmd.seed_step = 1'b1;
				if (status.seed_last) begin
					state_d = S_IDLE;
				end
			end
			S_TW_PRE: begin
				cmd.tw_pre = 1'b1;
				state_d    = S_TW_RUN;
			end
			S_TW_RUN: begin
				cmd.tw_issue = 1'b1;
				if (status.tw_last) begin
					state_d = S_TW_LAST;
				end
			end
			S_TW_LAST: begin
				cmd.idx_clear = 1'b1;
				state_d       = S_READ;
			end
			S_READ: begin
				cmd.rd_draw = 1'b1;
				state_d     = S_TEMPER;
			end
			S_TEMPER: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the seeding of the reset seed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SEED;
		end else begin
			state_q <= state_d;
		end
	end

	// A draw with an exhausted index regenerates the state first.
	a_draw_twists: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_DRAW && status.idx_full |=> state_q == S_TW_PRE)
		else $error("draw at full index did not start a twist");

	// The last twist issue is followed by the drain cycle.
	a_twist_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TW_RUN && status.tw_last |=> state_q == S_TW_LAST)
		else $error("twist did not drain after its last word");

	// A tempered word is always followed by readiness for the next request.
	a_temper_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TEMPER |=> !busy)
		else $error("controller stayed busy after presenting a word");

endmodule
`default_nettype wire

// ===== rtl/core/mtg_datapath.sv =====
// Datapath for the MT19937 word generator: state RAM, seed expansion,
// twist pipeline, word index and tempered output. Depends on mtg_pkg, mtg_ram.
`default_nettype none
module mtg_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mtg_pkg::cmd_t              cmd,
	input  wire logic [mtg_pkg::WORD_W-1:0] seed_value,
	output mtg_pkg::status_t                status,
	output logic      [mtg_pkg::WORD_W-1:0] random_word,
	output logic                            done
);
	import mtg_pkg::*;

	logic [ADDR_W-1:0] k_q;
	logic [ADDR_W-1:0] k_s1;
	logic              twv_s1;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] p_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] word_q;
	logic              done_q;

	logic [ADDR_W-1:0] nxt_addr;
	logic [ADDR_W:0]   far_sum;
	logic [ADDR_W-1:0] far_addr;
	logic [ADDR_W-1:0] raddr0;
	logic [WORD_W-1:0] rdata0;
	logic [WORD_W-1:0] rdata1;
	logic [WORD_W-1:0] seed_mix;
	logic [WORD_W-1:0] seed_prod;
	logic [WORD_W-1:0] seed_word;
	logic [WORD_W-1:0] tw_y;
	logic [WORD_W-1:0] tw_word;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;

	// Neighbor addresses of the word being twisted, wrapped at the state size.
	assign nxt_addr = (k_q == LAST_ADDR) ? '0 : k_q + ADDR_W'(1);
	assign far_sum  = {1'b0, k_q} + {1'b0, OFFS_ADDR};
	assign far_addr = (far_sum >= (ADDR_W + 1)'(STATE_WORDS)) ?
		ADDR_W'(far_sum - (ADDR_W + 1)'(STATE_WORDS)) : far_sum[ADDR_W-1:0];

	always_comb begin
		if (cmd.tw_pre) begin
			raddr0 = '0;
		end else if (cmd.tw_issue) begin
			raddr0 = nxt_addr;
		end else begin
			raddr0 = idx_q[ADDR_W-1:0];
		end
	end

	// Seed recurrence: previous word xored with itself shifted right by 30, times the multiplier, plus the position.
	assign seed_mix  = p_q ^ (p_q >> 30);
	assign seed_prod = WORD_W'(INIT_MULT * seed_mix);
	assign seed_word = (k_q == '0) ? p_q :
		seed_prod + {{(WORD_W - ADDR_W){1'b0}}, k_q};

	// Twist of one word from its current value and the fetched neighbors.
	assign tw_y    = (cur_q & UPPER_MASK) | (rdata0 & LOWER_MASK);
	assign tw_word = rdata1 ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : '0);

	// Write port: seeding or the twist pipeline, never both.
	always_comb begin
		we    = cmd.seed_step || twv_s1;
		waddr = cmd.seed_step ? k_q : k_s1;
		wdata = cmd.seed_step ? seed_word : tw_word;
	end

	mtg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(far_addr),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	// Counter, index and seed chain; reset starts with the reset seed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			twv_s1 <= 1'b0;
			idx_q  <= FULL_INDEX;
			p_q    <= RESET_SEED;
			done_q <= 1'b0;
		end else begin
			twv_s1 <= cmd.tw_issue;
			done_q <= cmd.out_load;
			if (cmd.seed_load || cmd.tw_pre) begin
				k_q <= '0;
			end else if (cmd.seed_step || cmd.tw_issue) begin
				k_q <= k_q + ADDR_W'(1);
			end
			if (cmd.seed_load) begin
				p_q <= seed_value;
			end else if (cmd.seed_step) begin
				p_q <= seed_word;
			end
			if (cmd.seed_load) begin
				idx_q <= FULL_INDEX;
			end else if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.out_load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Twist pipeline and output payload.
	always_ff @(posedge clk) begin
		k_s1  <= k_q;
		cur_q <= rdata0;
		if (cmd.out_load) begin
			word_q <= temper(rdata0);
		end
	end

	assign status.seed_last = (k_q == LAST_ADDR);
	assign status.tw_last   = (k_q == LAST_ADDR);
	assign status.idx_full  = (idx_q >= FULL_INDEX);
	assign random_word      = word_q;
	assign done             = done_q;

	// Seeding and twisting never write the RAM in the same cycle.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(twv_s1 && cmd.seed_step))
		else $error("seed and twist writes collide");

	// The index never passes the state size.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= FULL_INDEX)
		else $error("word index out of range");

	// A draw is never taken from an exhausted index.
	a_draw_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_draw |-> !status.idx_full)
		else $error("word fetched at full index");

endmodule
`default_nettype wire

// ===== rtl/core/mt19937_word_generator_unit.sv =====
// Top level of the MT19937 32-bit word generator: controller plus datapath.
// Depends on mtg_pkg, mtg_ctrl, mtg_datapath (and mtg_ram below it).
//
//   Channel   Handshake        Payload
//   request   start / busy     req_type, seed_value
//   word      done (strobe)    random_word
//
// A request is taken when start is high and busy is low.
// A draw passes through the read and temper states and raises done from a
// register; when the index is exhausted the 624-word state is regenerated
// first, one word per cycle through the RAM's two read ports.
// A seed request runs the expansion into the state, one word per cycle, and
// yields no word. After reset the block runs the same expansion of the
// reset seed with busy high. The receiver cannot stall: done lasts one cycle.
`default_nettype none
module mt19937_word_generator_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       req_type,
	input  wire logic [mtg_pkg::WORD_W-1:0] seed_value,
	output logic      [mtg_pkg::WORD_W-1:0] random_word,
	output logic                            done
);
	import mtg_pkg::*;

	cmd_t    cmd;
	status_t status;

	mtg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.status  (status),
		.busy    (busy),
		.cmd     (cmd)
	);

	mtg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.seed_value (seed_value),
		.status     (status),
		.random_word(random_word),
		.done       (done)
	);

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for mt19937_word_generator_unit: a directed table, a long run of
// draws, and random draws mixed with reseeds, all checked against an in-bench MT19937 model.
// Depends on mtg_pkg and the RTL under rtl/core.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mtg_pkg::*;

	// One row of the directed table; a typed-in word is used where it is well known.
	typedef struct {
		logic              req;
		logic [WORD_W-1:0] seed;
		bit                has_lit;
		logic [WORD_W-1:0] lit;
	} dir_row_t;

	localparam int N_DIR = 22;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              req_type = REQ_DRAW;
	logic [WORD_W-1:0] seed_value = '0;
	logic              busy;
	logic [WORD_W-1:0] random_word;
	logic              done;

	// Model state: the 624-word pool and the read position.
	logic [WORD_W-1:0] mt_words [STATE_WORDS];
	int                mt_pos;
	logic [WORD_W-1:0] pending_words [$];
	int                mismatches = 0;
	bit                steady = 1'b0;

	dir_row_t dir_rows [N_DIR] = '{
		'{REQ_DRAW, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_DRAW, 32'hffff_ffff, 1'b0, 32'd0},
		'{REQ_SEED, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_DRAW, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_DRAW, 32'h1234_5678, 1'b0, 32'd0},
		'{REQ_SEED, 32'hffff_ffff, 1'b0, 32'd0},
		'{REQ_DRAW, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_SEED, 32'd5489,      1'b0, 32'd0},
		'{REQ_DRAW, 32'h0000_0000, 1'b1, 32'd3499211612},
		'{REQ_DRAW, 32'h0000_0000, 1'b1, 32'd581869302},
		'{REQ_SEED, 32'd1,         1'b0, 32'd0},
		'{REQ_DRAW, 32'hffff_ffff, 1'b1, 32'd1791095845},
		'{REQ_SEED, 32'h8000_0000, 1'b0, 32'd0},
		'{REQ_SEED, 32'h7fff_ffff, 1'b0, 32'd0},
		'{REQ_DRAW, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_SEED, 32'h5555_5555, 1'b0, 32'd0},
		'{REQ_DRAW, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_SEED, 32'haaaa_aaaa, 1'b0, 32'd0},
		'{REQ_DRAW, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_DRAW, 32'h0000_0000, 1'b0, 32'd0},
		'{REQ_SEED, 32'h1357_9bdf, 1'b0, 32'd0},
		'{REQ_DRAW, 32'hffff_ffff, 1'b0, 32'd0}
	};

	mt19937_word_generator_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.seed_value (seed_value),
		.random_word(random_word),
		.done       (done)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Fill the pool from a seed with the multiplicative recurrence.
	function automatic void reseed_words(input logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] prev;
		mt_words[0] = seed;
		for (int i = 1; i < STATE_WORDS; i++) begin
			prev = mt_words[i-1];
			mt_words[i] = INIT_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
		end
		mt_pos = STATE_WORDS;
	endfunction

	// Regenerate the whole pool in place, as the standard twist does.
	function automatic void twist_words();
		logic [WORD_W-1:0] mixed;
		logic [WORD_W-1:0] nxt;
		logic [WORD_W-1:0] far;
		for (int k = 0; k < STATE_WORDS; k++) begin
			nxt = mt_words[(k + 1) % STATE_WORDS];
			far = mt_words[(k + TWIST_OFFSET) % STATE_WORDS];
			mixed = (mt_words[k] & UPPER_MASK) | (nxt & LOWER_MASK);
			mt_words[k] = far ^ (mixed >> 1) ^ (mixed[0] ? TWIST_MATRIX : '0);
		end
		mt_pos = 0;
	endfunction

	function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] raw);
		logic [WORD_W-1:0] t;
		t = raw ^ (raw >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		return t ^ (t >> 18);
	endfunction

	// Next word a draw returns; advances the model.
	function automatic logic [WORD_W-1:0] draw_word();
		logic [WORD_W-1:0] w;
		if (mt_pos >= STATE_WORDS) begin
			twist_words();
		end
		w = temper_word(mt_words[mt_pos]);
		mt_pos++;
		return w;
	endfunction

	// Mostly short gaps, a few long ones, and stretches with none at all.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady) begin
			return 0;
		end
		if (roll < 40) begin
			return 0;
		end
		if (roll < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 40);
	endfunction

	// Present one request, wait for it to be taken, then update the model.
	task automatic issue_request(input logic req, input logic [WORD_W-1:0] seed,
			input bit has_lit, input logic [WORD_W-1:0] lit);
		int gap;
		logic [WORD_W-1:0] w;
		start <= 1'b1;
		req_type <= req;
		seed_value <= seed;
		do begin
			@(posedge clk);
		end while (busy);
		if (req == REQ_SEED) begin
			reseed_words(seed);
		end else begin
			w = draw_word();
			pending_words.push_back(has_lit ? lit : w);
		end
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			req_type <= 1'($urandom_range(0, 1));
			seed_value <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Check each word as its strobe ends.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$error("random_word: unexpected word, actual %h", random_word);
				mismatches++;
			end else begin
				if (random_word !== pending_words[0]) begin
					$error("random_word: expected %h, actual %h", pending_words[0], random_word);
					mismatches++;
				end
				void'(pending_words.pop_front());
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int waited;
		logic [WORD_W-1:0] seed;
		reseed_words(RESET_SEED);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			issue_request(dir_rows[i].req, dir_rows[i].seed, dir_rows[i].has_lit,
				dir_rows[i].lit);
		end

		// A long run of draws with no reseed in between.
		for (int n = 0; n < 200; n++) begin
			if (n % 60 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			issue_request(REQ_DRAW, $urandom, 1'b0, '0);
		end

		// Draws mixed with occasional reseeds.
		for (int n = 0; n < 230; n++) begin
			if (n % 40 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 5))
					0: seed = '0;
					1: seed = '1;
					default: seed = $urandom;
				endcase
				issue_request(REQ_SEED, seed, 1'b0, '0);
			end else begin
				issue_request(REQ_DRAW, $urandom, 1'b0, '0);
			end
		end
		start <= 1'b0;

		for (waited = 0; pending_words.size() != 0 && waited < 5000; waited++) begin
			@(posedge clk);
		end
		// A trailing reseed may still be running; watch for stray words.
		repeat (700) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("random_word: %0d expected words never arrived", pending_words.size());
			mismatches += pending_words.size();
		end
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
